>>> sv/mbrr_pkg.sv
// Shared types and constants for the Modbus TCP read-register responder.
package mbrr_pkg;

    typedef struct packed {
        logic        command;
        logic [7:0]  frame_byte;
        logic [7:0]  load_index;
        logic [15:0] load_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       reply_last;
    } t_out_item;

    localparam logic CMD_FRAME_BYTE = 1'b0;
    localparam logic CMD_LOAD_REG   = 1'b1;

    localparam int FRAME_LEN = 12;
    localparam int POS_W     = 4;
    localparam int QTY_W     = 5;

    localparam logic [POS_W-1:0] POS_UNIT  = 4'd6;
    localparam logic [POS_W-1:0] POS_ADDR_HI = 4'd8;
    localparam logic [POS_W-1:0] POS_ADDR_LO = 4'd9;
    localparam logic [POS_W-1:0] POS_QTY_HI  = 4'd10;
    localparam logic [POS_W-1:0] POS_LAST    = 4'd11;

    localparam logic [POS_W-1:0] HDR_LEN_HI = 4'd4;
    localparam logic [POS_W-1:0] HDR_LEN_LO = 4'd5;
    localparam logic [POS_W-1:0] HDR_BCOUNT = 4'd8;

    localparam logic [7:0] LEN_BASE = 8'd3;
    localparam logic [7:0] OWN_UNIT_RESET = 8'd1;

endpackage

>>> sv/modbus_tcp_read_register_responder.sv
// Top level of the Modbus TCP read-holding-registers responder.
// A twelfth request byte for this unit enters S_HEAD, which loads the first reply byte.
// A reply of 9 + 2*q bytes then leaves at one byte per cycle while the output is not stalled.
// Input is stalled for the whole reply; loads and other request bytes are accepted while idle.
// After reset the register file is cleared one entry at a time with the input stalled.
// The register file is one memory with one write port and one registered read port.
module modbus_tcp_read_register_responder
    import mbrr_pkg::*;
#(
    parameter int REG_COUNT    = 256,
    parameter int MAX_QUANTITY = 27
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam logic [IDX_W:0]   REG_COUNT_W = (IDX_W+1)'(REG_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(REG_COUNT - 1);
    localparam logic [QTY_W-1:0] QTY_MAX     = QTY_W'(MAX_QUANTITY);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HEAD  = 3'd2;
    localparam logic [2:0] S_HI    = 3'd3;
    localparam logic [2:0] S_LO    = 3'd4;

    logic [15:0]      r_mem [REG_COUNT];
    logic [15:0]      r_rd_data;
    logic [IDX_W-1:0] r_rd_addr, n_rd_addr;
    logic [IDX_W-1:0] r_clr_addr;

    logic [7:0]       r_req [FRAME_LEN];
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_cnt, n_cnt;
    logic [2:0]       r_state, n_state;
    logic [QTY_W-1:0] r_qty, n_qty;
    logic [QTY_W-1:0] r_words, n_words;
    logic [7:0]       r_lo, n_lo;
    logic [7:0]       r_own_unit;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic [IDX_W-1:0] w_ld_mod [256];
    logic [IDX_W-1:0] w_hi_mod [256];
    logic [IDX_W-1:0] w_lo_mod [256];

    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign w_ld_mod[g] = IDX_W'(g % REG_COUNT);
        assign w_hi_mod[g] = IDX_W'((g * 256) % REG_COUNT);
        assign w_lo_mod[g] = IDX_W'(g % REG_COUNT);
    end

    logic             w_in_acc, w_frame_acc, w_load_acc, w_frame_end, w_can_load;
    logic [15:0]      w_qty_raw;
    logic [QTY_W-1:0] w_qty;
    logic [IDX_W:0]   w_addr_sum;
    logic [IDX_W-1:0] w_start, w_next_addr;
    logic [7:0]       w_bcount, w_len, w_hdr_byte;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_frame_acc = w_in_acc && (i_in.command == CMD_FRAME_BYTE);
    assign w_load_acc  = w_in_acc && (i_in.command == CMD_LOAD_REG);
    assign w_frame_end = w_frame_acc && (r_pos == POS_LAST);
    assign w_can_load  = !r_out_valid || !i_out_stall;

    assign w_qty_raw  = {r_req[POS_QTY_HI], i_in.frame_byte};
    assign w_qty      = (w_qty_raw > 16'(MAX_QUANTITY)) ? QTY_MAX : w_qty_raw[QTY_W-1:0];
    assign w_addr_sum = {1'b0, w_hi_mod[r_req[POS_ADDR_HI]]}
                      + {1'b0, w_lo_mod[r_req[POS_ADDR_LO]]};
    assign w_start    = (w_addr_sum >= REG_COUNT_W) ? IDX_W'(w_addr_sum - REG_COUNT_W)
                                                    : w_addr_sum[IDX_W-1:0];
    assign w_next_addr = (r_rd_addr == IDX_LAST) ? '0 : r_rd_addr + 1'b1;

    assign w_bcount = {2'b00, r_qty, 1'b0};
    assign w_len    = LEN_BASE + w_bcount;

    always_comb begin
        case (r_cnt)
            HDR_LEN_HI: w_hdr_byte = 8'd0;
            HDR_LEN_LO: w_hdr_byte = w_len;
            HDR_BCOUNT: w_hdr_byte = w_bcount;
            default:    w_hdr_byte = r_req[r_cnt];
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_qty       = r_qty;
        n_words     = r_words;
        n_lo        = r_lo;
        n_rd_addr   = r_rd_addr;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == IDX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_frame_end && (r_req[POS_UNIT] == r_own_unit)) begin
                    n_state   = S_HEAD;
                    n_cnt     = '0;
                    n_qty     = w_qty;
                    n_words   = w_qty;
                    n_rd_addr = w_start;
                end
            end
            S_HEAD: begin
                if (w_can_load) begin
                    n_out_valid      = 1'b1;
                    n_out.reply_byte = w_hdr_byte;
                    n_out.reply_last = (r_cnt == HDR_BCOUNT) && (r_qty == '0);
                    n_cnt            = r_cnt + 1'b1;
                    if (r_cnt == HDR_BCOUNT) begin
                        n_state = (r_qty == '0) ? S_IDLE : S_HI;
                    end
                end
            end
            S_HI: begin
                if (w_can_load) begin
                    n_out_valid      = 1'b1;
                    n_out.reply_byte = r_rd_data[15:8];
                    n_out.reply_last = 1'b0;
                    n_lo             = r_rd_data[7:0];
                    n_rd_addr        = w_next_addr;
                    n_state          = S_LO;
                end
            end
            S_LO: begin
                if (w_can_load) begin
                    n_out_valid      = 1'b1;
                    n_out.reply_byte = r_lo;
                    n_out.reply_last = (r_words == QTY_W'(1));
                    n_words          = r_words - 1'b1;
                    n_state          = (r_words == QTY_W'(1)) ? S_IDLE : S_HI;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_mem[r_clr_addr] <= '0;
        end else if (w_load_acc) begin
            r_mem[w_ld_mod[i_in.load_index]] <= i_in.load_value;
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_frame_acc) begin
            r_req[r_pos] <= i_in.frame_byte;
        end
        r_cnt     <= n_cnt;
        r_qty     <= n_qty;
        r_words   <= n_words;
        r_lo      <= n_lo;
        r_rd_addr <= n_rd_addr;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_own_unit  <= OWN_UNIT_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_frame_acc) begin
                r_pos <= (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
            end
            if (i_cfg_we) begin
                r_own_unit <= i_cfg_wdata;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_no_reply_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_out_valid)
        else $error("reply transaction during register file clear");

    a_words_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HI || r_state == S_LO) |-> (r_words != '0))
        else $error("data phase with no words left");

    a_lo_follows_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HI) && w_can_load |=> (r_state == S_LO))
        else $error("high byte not followed by low byte");

endmodule
